// ===== design/vec3_normalize_macros.svh =====
// Assertion macros shared by the verification files of vec3_normalize.
// Depends on signals named clk and rst in the module that uses them.
`ifndef VEC3_NORMALIZE_MACROS_SVH
`define VEC3_NORMALIZE_MACROS_SVH

// Checked property, switched off while reset is high.
`define V3N_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("vec3_normalize check failed");

// Checked property that also holds during reset.
`define V3N_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("vec3_normalize reset check failed");

`endif

// ===== design/v3n_pkg.sv =====
// Shared types and constants of the vec3_normalize block.
// No dependencies.
package v3n_pkg;

  localparam int FIELD_W       = 24;
  localparam int THR_W         = 23;
  localparam int SUM_W         = 48;
  localparam int LEN_W         = 24;
  localparam int FRAC_BITS_DEF = 16;
  localparam int REG_IDX_W     = 1;
  localparam int CFG_W         = 23;

  localparam logic [THR_W-1:0]   THR_RESET = 23'd1;
  localparam logic [FIELD_W-1:0] POS_MAX   = 24'h7FFFFF;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_NORM_THR = 1'b0,
    REG_DIV_THR  = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_NORM     = 2'd0,
    ST_FALLBACK = 2'd1,
    ST_PASS     = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] vec_x;
    logic signed [FIELD_W-1:0] vec_y;
    logic signed [FIELD_W-1:0] vec_z;
  } in_word_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] out_x;
    logic signed [FIELD_W-1:0] out_y;
    logic signed [FIELD_W-1:0] out_z;
    logic [LEN_W-1:0]          length;
    status_t                   status;
  } out_word_t;

  // Magnitude of a signed component; the most negative value maps to 2^23.
  function automatic logic [FIELD_W-1:0] mag_of(logic signed [FIELD_W-1:0] v);
    return v[FIELD_W-1] ? FIELD_W'(-v) : FIELD_W'(v);
  endfunction

endpackage

// ===== design/v3n_sqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Depends on nothing but its parameters; side data travels with each word.
module v3n_sqrt #(
  parameter int IN_W   = 48,
  parameter int SIDE_W = 72
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [IN_W-1:0]     in_rad,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output logic [IN_W/2-1:0]   out_root,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int OUT_W = IN_W / 2;
  localparam int TW    = IN_W + 1;

  logic              vld  [0:OUT_W];
  logic [TW-1:0]     rem  [0:OUT_W];
  logic [OUT_W-1:0]  root [0:OUT_W];
  logic [SIDE_W-1:0] side [0:OUT_W];

  assign vld[0]  = in_valid;
  assign rem[0]  = TW'(in_rad);
  assign root[0] = '0;
  assign side[0] = in_side;

  // Stage i settles root bit OUT_W-1-i against the running remainder.
  for (genvar i = 0; i < OUT_W; i++) begin : g_stage
    localparam int B = OUT_W - 1 - i;
    logic [TW-1:0]    trial;
    logic [TW-1:0]    rem_next;
    logic [OUT_W-1:0] root_next;

    always_comb begin
      trial = (TW'(root[i]) << (B + 1)) | (TW'(1) << (2 * B));
      if (rem[i] >= trial) begin
        rem_next  = rem[i] - trial;
        root_next = root[i] | (OUT_W'(1) << B);
      end else begin
        rem_next  = rem[i];
        root_next = root[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        rem[i+1]  <= rem_next;
        root[i+1] <= root_next;
        side[i+1] <= side[i];
      end
    end
  end

  assign out_valid = vld[OUT_W];
  assign out_root  = root[OUT_W];
  assign out_side  = side[OUT_W];

endmodule

// ===== design/v3n_div.sv =====
// Pipelined three-lane restoring divider giving (mag << FRAC_BITS) / len.
// Uses v3n_pkg widths; assumes every magnitude is at most the divisor.
module v3n_div
  import v3n_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SIDE_W    = 98
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [FIELD_W-1:0] in_mag [0:2],
  input  logic [LEN_W-1:0]   in_len,
  input  logic [SIDE_W-1:0]  in_side,
  output logic               out_valid,
  output logic [FRAC_BITS:0] out_quo [0:2],
  output logic [SIDE_W-1:0]  out_side
);

  localparam int QW    = FRAC_BITS + 1;
  localparam int REM_W = LEN_W + 1;

  logic              vld  [0:QW];
  logic [REM_W-1:0]  rem  [0:QW][0:2];
  logic [QW-1:0]     quo  [0:QW][0:2];
  logic [LEN_W-1:0]  dvsr [0:QW];
  logic [SIDE_W-1:0] side [0:QW];
  logic [2:0]        lsb;

  // The top bits of the dividend are already below the divisor.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rem[0][l] = REM_W'(in_mag[l] >> 1);
      quo[0][l] = '0;
      lsb[l]    = in_mag[l][0];
    end
  end
  assign vld[0]  = in_valid;
  assign dvsr[0] = in_len;
  assign side[0] = in_side;

  // Stage j shifts in one dividend bit per lane and settles one quotient bit.
  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [REM_W-1:0] shifted [0:2];
    logic [REM_W-1:0] rem_next [0:2];
    logic [QW-1:0]    quo_next [0:2];

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        shifted[l] = {rem[j][l][REM_W-2:0], (j == 0) ? lsb[l] : 1'b0};
        if (shifted[l] >= REM_W'(dvsr[j])) begin
          rem_next[l] = shifted[l] - REM_W'(dvsr[j]);
          quo_next[l] = {quo[j][l][QW-2:0], 1'b1};
        end else begin
          rem_next[l] = shifted[l];
          quo_next[l] = {quo[j][l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          rem[j+1][l] <= rem_next[l];
          quo[j+1][l] <= quo_next[l];
        end
        dvsr[j+1] <= dvsr[j];
        side[j+1] <= side[j];
      end
    end
  end

  assign out_valid = vld[QW];
  assign out_side  = side[QW];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      out_quo[l] = quo[QW][l];
    end
  end

endmodule

// ===== design/vec3_normalize.sv =====
// Top level of vec3_normalize: square, sum, root, decide, divide, output.
// Depends on v3n_pkg, v3n_sqrt and v3n_div.
//
// Use: a vector word enters on vec/vec_valid and is taken at a clock edge
// where vec_valid is high and vec_stall is low. One result word per vector
// leaves on res/res_valid and is taken where res_valid is high and
// res_stall is low. Results keep the order of the vectors.
// The pipeline is the squares register, the sum register, 24 square-root
// stages, the decision register, FRAC_BITS + 1 divider stages and the
// output register.
// Throughput is one vector per cycle while res is not stalled; every stage
// is a register stage. When res is stalled with a word waiting, the whole
// pipeline holds and vec_stall goes high; nothing is dropped or repeated.
// Reset clears all valid bits and sets both thresholds to 1.
// The thresholds are written on cfg_we/cfg_index/cfg_data; the user must
// write them only while the block holds no vectors, unchecked by the block.
module vec3_normalize
  import v3n_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 vec_valid,
  output logic                 vec_stall,
  input  in_word_t             vec,
  output logic                 res_valid,
  input  logic                 res_stall,
  output out_word_t            res
);

  localparam int QW     = FRAC_BITS + 1;
  localparam int RAW_W  = $bits(in_word_t);
  localparam int SIDE_W = RAW_W + LEN_W + 2;
  localparam logic [FIELD_W-1:0] UNIT =
    (FRAC_BITS >= FIELD_W - 1) ? POS_MAX : (FIELD_W'(1) << FRAC_BITS);

  logic advance;
  logic [THR_W-1:0] norm_thr;
  logic [THR_W-1:0] div_thr;

  // The pipeline moves whenever the output register is free or being taken.
  assign advance   = !res_valid || !res_stall;
  assign vec_stall = !advance;

  // Threshold registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      norm_thr <= THR_RESET;
      div_thr  <= THR_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_NORM_THR: norm_thr <= cfg_data;
        REG_DIV_THR:  div_thr  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Squares of the component magnitudes.
  logic             s1_valid;
  in_word_t         s1_raw;
  logic [SUM_W-1:0] s1_sq [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= vec_valid;
    end
    if (advance) begin
      s1_raw   <= vec;
      s1_sq[0] <= mag_of(vec.vec_x) * mag_of(vec.vec_x);
      s1_sq[1] <= mag_of(vec.vec_y) * mag_of(vec.vec_y);
      s1_sq[2] <= mag_of(vec.vec_z) * mag_of(vec.vec_z);
    end
  end

  // Sum of squares; it stays below 2^48 for any input.
  logic             s2_valid;
  in_word_t         s2_raw;
  logic [SUM_W-1:0] s2_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
    if (advance) begin
      s2_raw <= s1_raw;
      s2_sum <= s1_sq[0] + s1_sq[1] + s1_sq[2];
    end
  end

  // Truncated square root.
  logic             rt_valid;
  logic [LEN_W-1:0] rt_len;
  logic [RAW_W-1:0] rt_side;

  v3n_sqrt #(
    .IN_W   (SUM_W),
    .SIDE_W (RAW_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (s2_valid),
    .in_rad    (s2_sum),
    .in_side   (s2_raw),
    .out_valid (rt_valid),
    .out_root  (rt_len),
    .out_side  (rt_side)
  );

  // Decide the case from the length and the thresholds.
  in_word_t         rt_raw;
  status_t          dec_status;
  logic             d_valid;
  in_word_t         d_raw;
  logic [LEN_W-1:0] d_len;
  status_t          d_status;
  logic [FIELD_W-1:0] d_mag [0:2];

  assign rt_raw = in_word_t'(rt_side);

  always_comb begin
    if (!(rt_len > LEN_W'(norm_thr))) begin
      dec_status = ST_FALLBACK;
    end else if (rt_len < LEN_W'(div_thr)) begin
      dec_status = ST_PASS;
    end else begin
      dec_status = ST_NORM;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (advance) begin
      d_valid <= rt_valid;
    end
    if (advance) begin
      d_raw    <= rt_raw;
      d_len    <= rt_len;
      d_status <= dec_status;
      d_mag[0] <= mag_of(rt_raw.vec_x);
      d_mag[1] <= mag_of(rt_raw.vec_y);
      d_mag[2] <= mag_of(rt_raw.vec_z);
    end
  end

  // Component division.
  logic              dv_valid;
  logic [QW-1:0]     dv_quo [0:2];
  logic [SIDE_W-1:0] dv_side;

  v3n_div #(
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (d_valid),
    .in_mag    (d_mag),
    .in_len    (d_len),
    .in_side   ({d_raw, d_len, d_status}),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_side  (dv_side)
  );

  // Assemble the result word.
  in_word_t           o_raw;
  logic [LEN_W-1:0]   o_len;
  status_t            o_status;
  logic [FIELD_W-1:0] o_sat [0:2];
  logic [FIELD_W-1:0] o_sgn [0:2];
  logic [2:0]         o_neg;
  out_word_t          res_next;

  assign o_raw    = in_word_t'(dv_side[SIDE_W-1 -: RAW_W]);
  assign o_len    = dv_side[LEN_W+1:2];
  assign o_status = status_t'(dv_side[1:0]);
  assign o_neg    = {o_raw.vec_x[FIELD_W-1], o_raw.vec_y[FIELD_W-1],
                     o_raw.vec_z[FIELD_W-1]};

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if ((QW + FIELD_W)'(dv_quo[l]) > (QW + FIELD_W)'(POS_MAX)) begin
        o_sat[l] = POS_MAX;
      end else begin
        o_sat[l] = FIELD_W'(dv_quo[l]);
      end
      o_sgn[l] = o_neg[2-l] ? FIELD_W'(-o_sat[l]) : o_sat[l];
    end
    res_next.length = o_len;
    res_next.status = o_status;
    case (o_status)
      ST_FALLBACK: begin
        res_next.out_x = UNIT;
        res_next.out_y = '0;
        res_next.out_z = '0;
      end
      ST_PASS: begin
        res_next.out_x = o_raw.vec_x;
        res_next.out_y = o_raw.vec_y;
        res_next.out_z = o_raw.vec_z;
      end
      default: begin
        res_next.out_x = o_sgn[0];
        res_next.out_y = o_sgn[1];
        res_next.out_z = o_sgn[2];
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= dv_valid;
    end
    if (advance) begin
      res <= res_next;
    end
  end

endmodule

// ===== design/v3n_check.sv =====
// Port-level checks of vec3_normalize, bound to the top level.
// Depends on v3n_pkg and vec3_normalize_macros.svh.
`include "vec3_normalize_macros.svh"

module v3n_check
  import v3n_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      vec_valid,
  input logic      vec_stall,
  input in_word_t  vec,
  input logic      res_valid,
  input logic      res_stall,
  input out_word_t res
);

  // A stalled result word stays put.
  `V3N_ASSERT(a_res_hold, res_valid && res_stall |=> res_valid && $stable(res))

  // Input is held back only while a result word waits on a stalled receiver.
  `V3N_ASSERT(a_stall_cause, vec_stall |-> res_valid && res_stall)

  // The fallback word, the unit x vector, has zero y and z components.
  `V3N_ASSERT(a_fallback, res_valid && res.status == ST_FALLBACK |-> res.out_y == '0 && res.out_z == '0)

  // Reset empties the pipeline.
  `V3N_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !res_valid)

endmodule

bind vec3_normalize v3n_check u_check (.*);

// ===== sim/tb.sv =====
// Self-checking testbench for vec3_normalize: random and directed vectors,
// predicted results compared word by word. Depends on v3n_pkg and the RTL.
`timescale 1ns / 100ps

module tb;
  import v3n_pkg::*;

  localparam int FRAC_BITS = FRAC_BITS_DEF;
  localparam int LATENCY   = FRAC_BITS + 29;
  localparam int WDOG_MAX  = 20000;
  localparam int HOLD_LEN  = 300;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 vec_valid;
  logic                 vec_stall;
  in_word_t             vec;
  logic                 res_valid;
  logic                 res_stall;
  out_word_t            res;

  vec3_normalize #(.FRAC_BITS(FRAC_BITS)) u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .vec_valid(vec_valid), .vec_stall(vec_stall),
    .vec(vec), .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  // Threshold copies, pending vectors and predicted result words.
  logic [THR_W-1:0] norm_thr;
  logic [THR_W-1:0] div_thr;
  in_word_t         pending_vecs[$];
  out_word_t        expected_words[$];
  int               n_errors = 0;
  int               n_results = 0;
  int               n_by_status[3];
  int               hold_cycles;
  logic             hold_req;
  logic             hold_done;
  int               wdog;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Truncated integer square root of a 64-bit value.
  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Component over length as signed Q8.16, truncated toward zero.
  function automatic logic [FIELD_W-1:0] scale_comp(logic signed [FIELD_W-1:0] c,
                                                    logic [63:0] len);
    logic [63:0] m;
    logic [63:0] q;
    m = c[FIELD_W-1] ? 64'(-64'(c)) : 64'(c);
    q = (m << FRAC_BITS) / len;
    if (q > 64'(POS_MAX)) q = 64'(POS_MAX);
    return c[FIELD_W-1] ? FIELD_W'(-q) : FIELD_W'(q);
  endfunction

  // Expected result word for one vector under the current thresholds.
  function automatic out_word_t normalize_vec(in_word_t v);
    out_word_t   w;
    logic [63:0] ax, ay, az, len, one;
    ax = v.vec_x[FIELD_W-1] ? 64'(-64'(v.vec_x)) : 64'(v.vec_x);
    ay = v.vec_y[FIELD_W-1] ? 64'(-64'(v.vec_y)) : 64'(v.vec_y);
    az = v.vec_z[FIELD_W-1] ? 64'(-64'(v.vec_z)) : 64'(v.vec_z);
    len = int_sqrt(ax * ax + ay * ay + az * az);
    w.length = len[LEN_W-1:0];
    if (!(len > 64'(norm_thr))) begin
      one = 64'd1 << FRAC_BITS;
      if (one > 64'(POS_MAX)) one = 64'(POS_MAX);
      w.out_x = one[FIELD_W-1:0];
      w.out_y = '0;
      w.out_z = '0;
      w.status = ST_FALLBACK;
    end else if (len < 64'(div_thr)) begin
      w.out_x = v.vec_x;
      w.out_y = v.vec_y;
      w.out_z = v.vec_z;
      w.status = ST_PASS;
    end else begin
      w.out_x = scale_comp(v.vec_x, len);
      w.out_y = scale_comp(v.vec_y, len);
      w.out_z = scale_comp(v.vec_z, len);
      w.status = ST_NORM;
    end
    return w;
  endfunction

  // Random component: mostly full range, sometimes small or extreme.
  function automatic logic [FIELD_W-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return FIELD_W'($signed($urandom_range(0, 8)) - 4);
      1: return FIELD_W'($signed($urandom_range(0, 1024)) - 512);
      2: return $urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF;
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  // Driver: offers the oldest pending vector, with a random gap per word.
  int send_gap;
  always @(posedge clk) begin
    if (rst) begin
      vec_valid <= 1'b0;
      vec       <= '0;
      send_gap  <= 0;
    end else if (vec_valid && !vec_stall) begin
      expected_words.push_back(normalize_vec(vec));
      if (send_gap == 0 && pending_vecs.size() > 0) begin
        vec <= pending_vecs.pop_front();
      end else begin
        vec_valid <= 1'b0;
      end
      send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    end else if (!vec_valid) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (pending_vecs.size() > 0) begin
        vec       <= pending_vecs.pop_front();
        vec_valid <= 1'b1;
      end
    end
  end

  // Monitor: takes result words, checks them and draws the next stall.
  int recv_gap;
  always @(posedge clk) begin
    out_word_t exp_w;
    int        errs;
    errs = 0;
    if (rst) begin
      res_stall   <= 1'b0;
      recv_gap    <= 0;
      hold_cycles <= 0;
      hold_done   <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        n_results <= n_results + 1;
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected");
          errs++;
        end else begin
          exp_w = expected_words.pop_front();
          if (exp_w.status <= ST_PASS) n_by_status[exp_w.status]++;
          if (res.out_x !== exp_w.out_x) begin
            $error("out_x expected %0h actual %0h", exp_w.out_x, res.out_x);
            errs++;
          end
          if (res.out_y !== exp_w.out_y) begin
            $error("out_y expected %0h actual %0h", exp_w.out_y, res.out_y);
            errs++;
          end
          if (res.out_z !== exp_w.out_z) begin
            $error("out_z expected %0h actual %0h", exp_w.out_z, res.out_z);
            errs++;
          end
          if (res.length !== exp_w.length) begin
            $error("length expected %0h actual %0h", exp_w.length, res.length);
            errs++;
          end
          if (res.status !== exp_w.status) begin
            $error("status expected %0d actual %0d", exp_w.status, res.status);
            errs++;
          end
        end
      end
      n_errors <= n_errors + errs;
      // A long hold, when asked for, takes precedence over short stalls.
      if (hold_req && !hold_done) begin
        res_stall   <= 1'b1;
        hold_cycles <= HOLD_LEN - 1;
        hold_done   <= 1'b1;
      end else if (hold_cycles > 0) begin
        res_stall   <= 1'b1;
        hold_cycles <= hold_cycles - 1;
      end else if (recv_gap > 0) begin
        res_stall <= 1'b1;
        recv_gap  <= recv_gap - 1;
      end else begin
        res_stall <= 1'b0;
        if (res_valid && !res_stall)
          recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if (rst || (vec_valid && !vec_stall) || (res_valid && !res_stall)) begin
      wdog <= 0;
    end else begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_vecs.size() > 0 || vec_valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_thr(reg_idx_t idx, logic [THR_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_NORM_THR) norm_thr = val;
    else div_thr = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic queue_vec(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y,
                           logic [FIELD_W-1:0] z);
    in_word_t v;
    v.vec_x = x;
    v.vec_y = y;
    v.vec_z = z;
    pending_vecs.push_back(v);
  endtask

  task automatic random_phase(int count);
    repeat (count) queue_vec(rand_comp(), rand_comp(), rand_comp());
    wait_drained();
  endtask

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_NORM_THR;
    cfg_data  = '0;
    norm_thr  = THR_RESET;
    div_thr   = THR_RESET;
    hold_req  = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words under reset thresholds: zero, unit, extremes, signs.
    queue_vec(24'h0, 24'h0, 24'h0);
    queue_vec(24'h1, 24'h0, 24'h0);
    queue_vec(24'h0, 24'h2, 24'h0);
    queue_vec(24'h0, 24'h0, 24'hFFFFFE);
    queue_vec(24'h010000, 24'h0, 24'h0);
    queue_vec(24'hFF0000, 24'h0, 24'h0);
    queue_vec(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    queue_vec(24'h800000, 24'h800000, 24'h800000);
    queue_vec(24'h800000, 24'h7FFFFF, 24'h0);
    queue_vec(24'h030000, 24'hFC0000, 24'h0);
    queue_vec(24'h555555, 24'hAAAAAA, 24'h123456);
    wait_drained();

    // Thresholds that force fallback, pass-through and their overlap.
    write_thr(REG_NORM_THR, 23'h7FFFFF);
    write_thr(REG_DIV_THR, 23'h7FFFFF);
    queue_vec(24'h7FFFFF, 24'h0, 24'h0);
    queue_vec(24'h800000, 24'h800000, 24'h800000);
    queue_vec(24'h000100, 24'h0, 24'h0);
    wait_drained();
    write_thr(REG_NORM_THR, 23'd0);
    queue_vec(24'h1, 24'h0, 24'h0);
    queue_vec(24'hFFFFFF, 24'hFFFFFF, 24'h1);
    queue_vec(24'h400000, 24'hC00000, 24'h0);
    queue_vec(24'h800000, 24'h800000, 24'h800000);
    wait_drained();
    write_thr(REG_DIV_THR, 23'd0);
    queue_vec(24'h1, 24'h0, 24'h0);
    queue_vec(24'h800000, 24'h0, 24'h0);
    wait_drained();

    // Random phases over several threshold settings.
    write_thr(REG_NORM_THR, 23'd1);
    write_thr(REG_DIV_THR, 23'd1);
    random_phase(400);
    write_thr(REG_NORM_THR, 23'd256);
    write_thr(REG_DIV_THR, 23'h080000);
    random_phase(400);
    write_thr(REG_NORM_THR, 23'h400000);
    write_thr(REG_DIV_THR, 23'h7FFFFF);
    random_phase(300);
    write_thr(REG_NORM_THR, THR_W'($urandom));
    write_thr(REG_DIV_THR, THR_W'($urandom));
    random_phase(300);

    // Long receiver hold while the sender keeps offering words.
    write_thr(REG_NORM_THR, 23'd0);
    write_thr(REG_DIV_THR, 23'd2000);
    hold_req = 1'b1;
    random_phase(300);
    write_thr(REG_NORM_THR, 23'd100);
    write_thr(REG_DIV_THR, 23'd0);
    random_phase(300);

    $display("Checked %0d result words: %0d normalized, %0d fallback, %0d passed.",
             n_results, n_by_status[ST_NORM], n_by_status[ST_FALLBACK],
             n_by_status[ST_PASS]);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/v3n_pkg.sv
design/v3n_sqrt.sv
design/v3n_div.sv
design/vec3_normalize.sv
design/v3n_check.sv
sim/tb.sv
